[sv/spadd_pkg.sv]
// ----------------------------------------------------------------------------
// spadd_pkg: shared types and constants for the sparse polynomial adder
// Command codes, controller states and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spadd_pkg;

    localparam int MAX_TERMS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int COEF_W   = 16;
    localparam int EXP_W    = 16;
    localparam int SUM_W    = 17;

    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic wr_a;     // append request term to list A
        logic wr_b;     // append request term to list B
        logic emit;     // load output register with current head term, advance
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can take a term this cycle
        logic last_term;   // current head term ends the merge
        logic both_empty;  // both list counts are zero
    } dp_status_t;

endpackage

[sv/spadd_ctrl.sv]
// ----------------------------------------------------------------------------
// spadd_ctrl: merge sequencer
// Takes load and merge requests while idle; during a merge alternates the
// fetch and emit states, holding in emit while the output is full.
// ----------------------------------------------------------------------------
module spadd_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [spadd_pkg::CMD_W-1:0]       cmd,
    input  spadd_pkg::dp_status_t             status,
    output spadd_pkg::ctrl_cmd_t              ctl
);
    import spadd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        cmd_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    unique case (cmd)
                        CMD_LOAD_A: ctl.wr_a = 1'b1;
                        CMD_LOAD_B: ctl.wr_b = 1'b1;
                        CMD_MERGE:  state_next = S_FETCH;
                        default:    ;
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = status.last_term ? S_IDLE : S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/spadd_dpath.sv]
// ----------------------------------------------------------------------------
// spadd_dpath: term stores, merge pointers and output register
// Each list is a single-port-write, registered-read memory of packed
// {coefficient, exponent} words. Heads are compared and summed into the
// output register on an emit command.
// ----------------------------------------------------------------------------
module spadd_dpath #(
    parameter int MAX_TERMS = spadd_pkg::MAX_TERMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spadd_pkg::ctrl_cmd_t                 ctl,
    output spadd_pkg::dp_status_t                status,
    input  logic signed [spadd_pkg::COEF_W-1:0]  coefficient,
    input  logic [spadd_pkg::EXP_W-1:0]          exponent,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [spadd_pkg::SUM_W-1:0]   sum_coefficient,
    output logic [spadd_pkg::EXP_W-1:0]          sum_exponent,
    output logic                                 term_valid,
    output logic                                 last,
    output logic                                 dropped
);
    import spadd_pkg::*;

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int WW = COEF_W + EXP_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);

    logic [WW-1:0] mem_a [MAX_TERMS];
    logic [WW-1:0] mem_b [MAX_TERMS];
    logic [WW-1:0] rd_a_reg;
    logic [WW-1:0] rd_b_reg;

    logic [CW-1:0] count_a_reg;
    logic [CW-1:0] count_b_reg;
    logic [CW-1:0] ptr_a_reg;
    logic [CW-1:0] ptr_b_reg;
    logic [CW-1:0] ptr_a_next;
    logic [CW-1:0] ptr_b_next;
    logic          overflow_reg;

    logic                     out_valid_reg;
    logic signed [SUM_W-1:0]  out_coef_reg;
    logic [EXP_W-1:0]         out_exp_reg;
    logic                     out_term_reg;
    logic                     out_last_reg;
    logic                     out_drop_reg;

    logic                     a_more;
    logic                     b_more;
    logic                     take_a;
    logic                     take_b;
    logic signed [SUM_W-1:0]  coef_a;
    logic signed [SUM_W-1:0]  coef_b;
    logic [EXP_W-1:0]         exp_a;
    logic [EXP_W-1:0]         exp_b;
    logic signed [SUM_W-1:0]  sum_coef;
    logic [EXP_W-1:0]         sum_exp;
    logic                     a_full;
    logic                     b_full;

    assign a_full = (count_a_reg == FULL);
    assign b_full = (count_b_reg == FULL);

    // term stores; reads follow the merge pointers every cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_a && !a_full)
        begin
            mem_a[count_a_reg[AW-1:0]] <= {coefficient, exponent};
        end
        if (ctl.wr_b && !b_full)
        begin
            mem_b[count_b_reg[AW-1:0]] <= {coefficient, exponent};
        end
        rd_a_reg <= mem_a[ptr_a_reg[AW-1:0]];
        rd_b_reg <= mem_b[ptr_b_reg[AW-1:0]];
    end

    always_comb
    begin
        a_more  = (ptr_a_reg < count_a_reg);
        b_more  = (ptr_b_reg < count_b_reg);
        exp_a   = rd_a_reg[EXP_W-1:0];
        exp_b   = rd_b_reg[EXP_W-1:0];
        coef_a  = SUM_W'(signed'(rd_a_reg[WW-1:EXP_W]));
        coef_b  = SUM_W'(signed'(rd_b_reg[WW-1:EXP_W]));
        // equal exponents take both heads
        take_a  = a_more && (!b_more || (exp_a >= exp_b));
        take_b  = b_more && (!a_more || (exp_b >= exp_a));
        sum_coef = (take_a ? coef_a : '0) + (take_b ? coef_b : '0);
        sum_exp  = take_a ? exp_a : (take_b ? exp_b : '0);
        ptr_a_next = ptr_a_reg + CW'(take_a);
        ptr_b_next = ptr_b_reg + CW'(take_b);
    end

    assign status.out_free   = !out_valid_reg || !res_stall;
    assign status.last_term  = (ptr_a_next >= count_a_reg) && (ptr_b_next >= count_b_reg);
    assign status.both_empty = (count_a_reg == '0) && (count_b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_a)
            begin
                if (a_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_a_reg <= count_a_reg + CW'(1);
                end
            end
            if (ctl.wr_b)
            begin
                if (b_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    count_b_reg <= count_b_reg + CW'(1);
                end
            end

            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
                if (status.last_term)
                begin
                    count_a_reg  <= '0;
                    count_b_reg  <= '0;
                    ptr_a_reg    <= '0;
                    ptr_b_reg    <= '0;
                    overflow_reg <= 1'b0;
                end
                else
                begin
                    ptr_a_reg <= ptr_a_next;
                    ptr_b_reg <= ptr_b_next;
                end
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_coef_reg <= sum_coef;
            out_exp_reg  <= sum_exp;
            out_term_reg <= a_more || b_more;
            out_last_reg <= status.last_term;
            out_drop_reg <= overflow_reg;
        end
    end

    assign res_valid       = out_valid_reg;
    assign sum_coefficient = out_coef_reg;
    assign sum_exponent    = out_exp_reg;
    assign term_valid      = out_term_reg;
    assign last            = out_last_reg;
    assign dropped         = out_drop_reg;

endmodule

[sv/sparse_polynomial_add_merge.sv]
// ----------------------------------------------------------------------------
// sparse_polynomial_add_merge: sparse polynomial adder by list merge
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------------------
//   cmd      cmd_valid/cmd_stall  cmd, coefficient, exponent
//   res      res_valid/res_stall  sum_coefficient, sum_exponent,
//                                 term_valid, last, dropped
//
// A load request (list A or B) gives no result.
// A merge request gives its results one at a time, each from a memory read
// state followed by an emit state; the emit waits while the output is
// stalled. cmd_stall stays high for the merge.
// Reset clears both list counts and the drop flag; no clearing pass.
// The output register lets the last result wait while new loads go in.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_merge #(
    parameter int MAX_TERMS = spadd_pkg::MAX_TERMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  logic [spadd_pkg::CMD_W-1:0]          cmd,
    input  logic signed [spadd_pkg::COEF_W-1:0]  coefficient,
    input  logic [spadd_pkg::EXP_W-1:0]          exponent,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [spadd_pkg::SUM_W-1:0]   sum_coefficient,
    output logic [spadd_pkg::EXP_W-1:0]          sum_exponent,
    output logic                                 term_valid,
    output logic                                 last,
    output logic                                 dropped
);
    import spadd_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t status;

    spadd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .status    (status),
        .ctl       (ctl)
    );

    spadd_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .status          (status),
        .coefficient     (coefficient),
        .exponent        (exponent),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .sum_coefficient (sum_coefficient),
        .sum_exponent    (sum_exponent),
        .term_valid      (term_valid),
        .last            (last),
        .dropped         (dropped)
    );

    // never overwrite a result that is still waiting
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> status.out_free)
        else $error("emit while output register held");

    // the final term of a merge empties both lists
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && status.last_term) |=> status.both_empty)
        else $error("lists not emptied after merge");

    // a result only appears after an emit
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(ctl.emit))
        else $error("result valid without emit");

    // loads are never taken during a merge
    a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> !(ctl.wr_a || ctl.wr_b))
        else $error("list write while merging");

endmodule

[bench/merge_term_checker.sv]
// ----------------------------------------------------------------------------
// merge_term_checker: predicts and checks merged polynomial terms
// Watches the request and result channels of the sparse polynomial adder,
// keeps its own copy of both term lists, and on every accepted merge request
// queues the terms the merge must produce. Each accepted result is compared
// field by field with the oldest queued term.
// ----------------------------------------------------------------------------
module merge_term_checker #(
    parameter int MAX_TERMS = spadd_pkg::MAX_TERMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  logic                                 cmd_stall,
    input  logic [spadd_pkg::CMD_W-1:0]          cmd,
    input  logic signed [spadd_pkg::COEF_W-1:0]  coefficient,
    input  logic [spadd_pkg::EXP_W-1:0]          exponent,
    input  logic                                 res_valid,
    input  logic                                 res_stall,
    input  logic signed [spadd_pkg::SUM_W-1:0]   sum_coefficient,
    input  logic [spadd_pkg::EXP_W-1:0]          sum_exponent,
    input  logic                                 term_valid,
    input  logic                                 last,
    input  logic                                 dropped,
    output int                                   mismatches,
    output int                                   outstanding
);
    import spadd_pkg::*;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_coef;
        logic [EXP_W-1:0]        sum_exp;
        logic                    real_term;
        logic                    final_term;
        logic                    overflowed;
    } merged_term_t;

    logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
    logic [EXP_W-1:0]         a_exp  [MAX_TERMS];
    logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
    logic [EXP_W-1:0]         b_exp  [MAX_TERMS];
    int                       a_len;
    int                       b_len;
    logic                     lost_term;
    merged_term_t             merged_terms_q [$];
    merged_term_t             got;
    merged_term_t             want;
    int                       bad_count;

    assign mismatches = bad_count;

    function automatic void append_term(input logic to_b, input logic signed [COEF_W-1:0] c,
                                        input logic [EXP_W-1:0] e);
        if (!to_b && a_len < MAX_TERMS)
        begin
            a_coef[a_len] = c;
            a_exp[a_len]  = e;
            a_len++;
        end
        else if (to_b && b_len < MAX_TERMS)
        begin
            b_coef[b_len] = c;
            b_exp[b_len]  = e;
            b_len++;
        end
        else
        begin
            lost_term = 1'b1;
        end
    endfunction

    // walk both heads; once a list runs out the other one drains as is
    function automatic void merge_lists();
        int                      i;
        int                      j;
        logic signed [SUM_W-1:0] s;
        logic [EXP_W-1:0]        e;
        merged_term_t            t;
        i = 0;
        j = 0;
        if (a_len == 0 && b_len == 0)
        begin
            t.sum_coef   = '0;
            t.sum_exp    = '0;
            t.real_term  = 1'b0;
            t.final_term = 1'b1;
            t.overflowed = lost_term;
            merged_terms_q.push_back(t);
        end
        while (i < a_len || j < b_len)
        begin
            if (i < a_len && j < b_len && a_exp[i] == b_exp[j])
            begin
                s = SUM_W'(a_coef[i]);
                s = s + SUM_W'(b_coef[j]);
                e = a_exp[i];
                i++;
                j++;
            end
            else if (j >= b_len || (i < a_len && a_exp[i] > b_exp[j]))
            begin
                s = SUM_W'(a_coef[i]);
                e = a_exp[i];
                i++;
            end
            else
            begin
                s = SUM_W'(b_coef[j]);
                e = b_exp[j];
                j++;
            end
            t.sum_coef   = s;
            t.sum_exp    = e;
            t.real_term  = 1'b1;
            t.final_term = (i >= a_len && j >= b_len);
            t.overflowed = lost_term;
            merged_terms_q.push_back(t);
        end
        a_len     = 0;
        b_len     = 0;
        lost_term = 1'b0;
    endfunction

    function automatic void report_bad(input string what);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch (%s): expected coef %0d exp %0d valid %0b last %0b dropped %0b,",
                     what, want.sum_coef, want.sum_exp, want.real_term, want.final_term,
                     want.overflowed,
                     " got coef %0d exp %0d valid %0b last %0b dropped %0b",
                     got.sum_coef, got.sum_exp, got.real_term, got.final_term,
                     got.overflowed);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_len     = 0;
            b_len     = 0;
            lost_term = 1'b0;
            bad_count = 0;
            want      = '0;
            merged_terms_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a result never belongs to a merge taken at the same edge
            if (res_valid && !res_stall)
            begin
                got.sum_coef   = sum_coefficient;
                got.sum_exp    = sum_exponent;
                got.real_term  = term_valid;
                got.final_term = last;
                got.overflowed = dropped;
                if (merged_terms_q.size() == 0)
                begin
                    want = '0;
                    report_bad("unexpected term");
                end
                else
                begin
                    want = merged_terms_q.pop_front();
                    if (got.sum_coef != want.sum_coef || got.sum_exp != want.sum_exp ||
                        got.real_term != want.real_term ||
                        got.final_term != want.final_term ||
                        got.overflowed != want.overflowed)
                        report_bad("term");
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                case (cmd)
                    CMD_LOAD_A: append_term(1'b0, coefficient, exponent);
                    CMD_LOAD_B: append_term(1'b1, coefficient, exponent);
                    CMD_MERGE:  merge_lists();
                    default:    ;
                endcase
            end
            outstanding <= merged_terms_q.size();
        end
    end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: sparse polynomial adder by merge
// Loads term lists A and B and merges them: a directed opening covering
// extreme coefficients and exponents, zero sums, empty and one-sided merges,
// unordered lists, unused commands and list overflow, then random load and
// merge sequences under changing sender idle and receiver stall patterns.
// The checker beside the block predicts and compares every merged term.
// ----------------------------------------------------------------------------
module testbench;
    import spadd_pkg::*;

    localparam int               MAX_T        = MAX_TERMS_DEF;
    localparam int               RANDOM_ITEMS = 250;
    localparam int               CYCLE_LIMIT  = 1000000;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cmd_valid   = 1'b0;
    logic [CMD_W-1:0]         cmd         = '0;
    logic signed [COEF_W-1:0] coefficient = '0;
    logic [EXP_W-1:0]         exponent    = '0;
    logic                     res_stall   = 1'b0;
    logic                     cmd_stall;
    logic                     res_valid;
    logic signed [SUM_W-1:0]  sum_coefficient;
    logic [EXP_W-1:0]         sum_exponent;
    logic                     term_valid;
    logic                     last;
    logic                     dropped;
    int                       mismatches;
    int                       outstanding;
    int                       idle_pct    = 0;
    int                       stall_pct   = 0;
    int                       cycles      = 0;
    int                       sent        = 0;

    sparse_polynomial_add_merge #(.MAX_TERMS(MAX_T)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .cmd(cmd), .coefficient(coefficient), .exponent(exponent),
        .res_valid(res_valid), .res_stall(res_stall),
        .sum_coefficient(sum_coefficient), .sum_exponent(sum_exponent),
        .term_valid(term_valid), .last(last), .dropped(dropped)
    );

    merge_term_checker #(.MAX_TERMS(MAX_T)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .cmd(cmd), .coefficient(coefficient), .exponent(exponent),
        .res_valid(res_valid), .res_stall(res_stall),
        .sum_coefficient(sum_coefficient), .sum_exponent(sum_exponent),
        .term_valid(term_valid), .last(last), .dropped(dropped),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
        cycles    <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // one request; idle cycles in front of it, held until taken
    task automatic send(input logic [CMD_W-1:0] op, input logic signed [COEF_W-1:0] c,
                        input logic [EXP_W-1:0] e);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        cmd         <= op;
        coefficient <= c;
        exponent    <= e;
        do @(posedge clk); while (cmd_stall);
        if (op != CMD_UNUSED)
            sent++;
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic signed [COEF_W-1:0] pick_coef(input logic tiny);
        case ($urandom_range(0, 7))
            0:       pick_coef = 16'sh8000;
            1:       pick_coef = 16'sh7fff;
            default: pick_coef = tiny ? 16'($signed($urandom_range(0, 6)) - 3) : 16'($urandom);
        endcase
    endfunction

    function automatic int list_len();
        list_len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_T) : $urandom_range(0, 8);
    endfunction

    // well-formed descending lists from a shared base so exponents collide often,
    // loads of A and B interleaved at random, then a merge
    task automatic load_and_merge(input int na, input int nb, input logic tiny);
        logic [EXP_W-1:0] ea [$];
        logic [EXP_W-1:0] eb [$];
        int               base;
        int               ia;
        int               ib;
        int               e;
        base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535 - 4 * (na + nb) - 4);
        e = base;
        for (int k = 0; k < na; k++)
        begin
            ea.push_front(e[EXP_W-1:0]);
            e += $urandom_range(1, 3);
        end
        e = base;
        for (int k = 0; k < nb; k++)
        begin
            eb.push_front(e[EXP_W-1:0]);
            e += $urandom_range(1, 3);
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1))
            begin
                send(CMD_LOAD_A, pick_coef(tiny), ea[ia]);
                ia++;
            end
            else
            begin
                send(CMD_LOAD_B, pick_coef(tiny), eb[ib]);
                ib++;
            end
        end
        send(CMD_MERGE, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int phase;
        int next_phase;
        int pick;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme coefficients summed at both ends of the exponent range
        send(CMD_LOAD_A, 16'sh8000, 16'hffff);
        send(CMD_LOAD_B, 16'sh8000, 16'hffff);
        send(CMD_LOAD_A, 16'sh7fff, 16'h0000);
        send(CMD_LOAD_B, 16'sh7fff, 16'h0000);
        send(CMD_MERGE, 16'sh7fff, 16'hffff);
        // empty merge, and an unused command that must change nothing
        send(CMD_MERGE, 16'sh8000, 16'h0000);
        send(CMD_UNUSED, 16'sh5a5a, 16'ha5a5);
        send(CMD_MERGE, '0, '0);
        // zero sum kept, lists out of order
        send(CMD_LOAD_A, 16'sd5, 16'd10);
        send(CMD_LOAD_A, 16'sd7, 16'd20);
        send(CMD_LOAD_B, -16'sd5, 16'd10);
        send(CMD_LOAD_B, 16'sd1, 16'd3);
        send(CMD_MERGE, '0, '0);
        // one list only, each side
        send(CMD_LOAD_A, -16'sd1, 16'd100);
        send(CMD_LOAD_A, 16'sd2, 16'd50);
        send(CMD_MERGE, '0, '0);
        send(CMD_LOAD_B, 16'sd3, 16'd9);
        send(CMD_MERGE, '0, '0);
        // one term past capacity; the flag must clear after the merge
        for (int k = 0; k <= MAX_T; k++)
            send(CMD_LOAD_A, pick_coef(1'b0), 16'(1000 - k));
        send(CMD_MERGE, '0, '0);
        send(CMD_MERGE, '0, '0);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            next_phase = sent * 4 / RANDOM_ITEMS;
            if (next_phase != phase)
            begin
                // hold off until the block is empty before the pattern changes
                drain();
                phase = next_phase;
                case (phase)
                    1:
                    begin
                        idle_pct = 54;
                        stall_pct <= 0;
                    end
                    2:
                    begin
                        idle_pct = 0;
                        stall_pct <= 54;
                    end
                    default:
                    begin
                        idle_pct = 20;
                        stall_pct <= 20;
                    end
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                load_and_merge(list_len(), list_len(), $urandom_range(0, 3) == 0);
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 1)
                    load_and_merge(MAX_T + $urandom_range(1, 3), $urandom_range(0, 4), 1'b0);
                else
                    load_and_merge($urandom_range(0, 4), MAX_T + $urandom_range(1, 3), 1'b0);
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 6))
                    send(CMD_W'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
            end
            else
            begin
                send(CMD_MERGE, 16'($urandom), 16'($urandom));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
